// ===== sv/i2cmbc_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master byte controller package
// Action codes, phase counts and the shared result and pin types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cmbc_pkg;

   // Input action codes; the running command uses the same encoding.
   localparam logic [2:0] ACT_TICK      = 3'd0;
   localparam logic [2:0] ACT_START     = 3'd1;
   localparam logic [2:0] ACT_RESTART   = 3'd2;
   localparam logic [2:0] ACT_STOP      = 3'd3;
   localparam logic [2:0] ACT_WRITE     = 3'd4;
   localparam logic [2:0] ACT_READ      = 3'd5;
   localparam logic [2:0] CMD_IDLE      = 3'd0;

   // Reset value of the phase length register.
   localparam logic [15:0] PHASE_TICKS_RESET = 16'd128;

   // Bus pin levels driven by the master.
   typedef struct packed {
      logic scl;
      logic sda;
      logic drive;
   } pins_type;

   // One result item.
   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic       ack_received;
      logic [7:0] rx_byte;
      logic       rejected;
   } result_type;

   // Number of bus phases that each command runs.
   function automatic logic [4:0] phase_count(logic [2:0] cmd);
      logic [4:0] n;
      unique case (cmd)
         ACT_START:   n = 5'd3;
         ACT_RESTART: n = 5'd5;
         ACT_STOP:    n = 5'd4;
         ACT_WRITE:   n = 5'd27;
         ACT_READ:    n = 5'd21;
         default:     n = 5'd0;
      endcase
      return n;
   endfunction

endpackage

// ===== sv/i2cmbc_req_if.sv =====
// ----------------------------------------------------------------------------
// I2C master byte controller request channel
// Valid/ready channel that carries one tick or bus command per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface i2cmbc_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [7:0] tx_byte;
   logic       ack_to_send;
   logic       sda_in;

   modport source (output valid, output action, output tx_byte, output ack_to_send,
                   output sda_in, input ready);
   modport sink   (input valid, input action, input tx_byte, input ack_to_send,
                   input sda_in, output ready);
endinterface

// ===== sv/i2cmbc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// I2C master byte controller response channel
// Valid/ready channel that carries one result per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface i2cmbc_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_level;
   logic       sda_drive;
   logic       busy_res;
   logic       done_res;
   logic       ack_received;
   logic [7:0] rx_byte;
   logic       rejected;

   modport source (output valid, output scl_level, output sda_level, output sda_drive,
                   output busy_res, output done_res, output ack_received,
                   output rx_byte, output rejected, input ready);
   modport sink   (input valid, input scl_level, input sda_level, input sda_drive,
                   input busy_res, input done_res, input ack_received,
                   input rx_byte, input rejected, output ready);
endinterface

// ===== sv/i2cmbc_sequencer.sv =====
// ----------------------------------------------------------------------------
// I2C master byte controller phase sequencer
// Holds the command state, phase index, phase timer and pin levels, and
// advances them once for every accepted transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cmbc_sequencer #(
   parameter int TIMER_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [2:0]             action,
   input  logic [7:0]             tx_byte,
   input  logic                   ack_to_send,
   input  logic                   sda_in,
   input  logic                   csr_we,
   input  logic [15:0]            csr_wdata,
   output i2cmbc_pkg::result_type result
);

   logic [15:0]            phase_ticks_ff;
   logic [2:0]             cmd_ff,     cmd_in;
   logic [4:0]             idx_ff,     idx_in;
   logic [TIMER_WIDTH-1:0] timer_ff,   timer_in;
   logic [7:0]             shift_ff,   shift_in;
   logic                   ackflag_ff, ackflag_in;
   logic                   ackout_ff,  ackout_in;
   logic [7:0]             rx_ff,      rx_in;
   i2cmbc_pkg::pins_type   pins_ff,    pins_in;

   logic [TIMER_WIDTH-1:0] load_raw;
   logic [TIMER_WIDTH-1:0] load_val;
   logic [TIMER_WIDTH-1:0] timer_dec;
   logic [4:0]             idx_inc;
   logic [3:0]             rd_bit;
   logic                   done;
   logic                   rej;
   logic                   is_cmd;

   // Pin levels that a phase sets, given the command, the phase and the data.
   function automatic i2cmbc_pkg::pins_type set_phase(
      logic [2:0] cmd, logic [4:0] i, logic [7:0] shift, logic ackout,
      i2cmbc_pkg::pins_type cur);
      i2cmbc_pkg::pins_type p;
      logic [2:0]           b;
      logic [1:0]           r;
      p = cur;
      b = 3'd0;
      unique case (cmd)
         i2cmbc_pkg::ACT_START: begin
            p.drive = 1'b1;
            if (i == 5'd0) p.scl = 1'b1;
            else if (i == 5'd1) p.sda = 1'b0;
            else p.scl = 1'b0;
         end
         i2cmbc_pkg::ACT_RESTART: begin
            p.drive = 1'b1;
            if (i == 5'd0) p.scl = 1'b0;
            else if (i == 5'd1) p.sda = 1'b1;
            else if (i == 5'd2) p.scl = 1'b1;
            else if (i == 5'd3) p.sda = 1'b0;
            else p.scl = 1'b0;
         end
         i2cmbc_pkg::ACT_STOP: begin
            p.drive = 1'b1;
            if (i == 5'd0) p.sda = 1'b0;
            else if (i == 5'd1) p.scl = 1'b1;
            else if (i == 5'd2) p.sda = 1'b1;
         end
         i2cmbc_pkg::ACT_WRITE: begin
            if (i < 5'd24) begin
               // Three phases per bit: split the index into bit and step.
               for (int k = 1; k < 8; k++) begin
                  if (i >= 5'(3 * k)) b = 3'(k);
               end
               r = 2'(i - 5'(b) * 5'd3);
               if (r == 2'd0) p.scl = 1'b0;
               else if (r == 2'd1) begin
                  p.sda   = shift[3'd7 - b];
                  p.drive = 1'b1;
               end else p.scl = 1'b1;
            end else if (i == 5'd25) begin
               p.drive = 1'b0;
               p.scl   = 1'b1;
            end else begin
               p.scl = 1'b0;
            end
         end
         i2cmbc_pkg::ACT_READ: begin
            if (i == 5'd0) p.scl = 1'b0;
            else if (i <= 5'd16) begin
               if (i == 5'd1) begin
                  p.drive = 1'b0;
                  p.sda   = 1'b1;
               end
               p.scl = ~i[0];
            end else if (i == 5'd17) p.scl = 1'b0;
            else if (i == 5'd18) begin
               p.drive = 1'b1;
               p.sda   = ~ackout;
            end else if (i == 5'd19) p.scl = 1'b1;
            else p.scl = 1'b0;
         end
         default: begin
         end
      endcase
      return p;
   endfunction

   // Phase length, cut to the timer width, with zero taken as one tick.
   assign load_raw  = TIMER_WIDTH'(phase_ticks_ff);
   assign load_val  = (load_raw == '0) ? TIMER_WIDTH'(1) : load_raw;
   assign timer_dec = (timer_ff != '0) ? timer_ff - TIMER_WIDTH'(1) : '0;
   assign idx_inc   = idx_ff + 5'd1;
   assign rd_bit    = 4'd8 - idx_ff[4:1];
   assign is_cmd    = (action == i2cmbc_pkg::ACT_START) || (action == i2cmbc_pkg::ACT_RESTART)
                   || (action == i2cmbc_pkg::ACT_STOP) || (action == i2cmbc_pkg::ACT_WRITE)
                   || (action == i2cmbc_pkg::ACT_READ);

   // Next state for one transfer.
   always_comb begin
      cmd_in     = cmd_ff;
      idx_in     = idx_ff;
      timer_in   = timer_ff;
      shift_in   = shift_ff;
      ackflag_in = ackflag_ff;
      ackout_in  = ackout_ff;
      rx_in      = rx_ff;
      pins_in    = pins_ff;
      done       = 1'b0;
      rej        = 1'b0;
      if (accept) begin
         if (is_cmd) begin
            if (cmd_ff != i2cmbc_pkg::CMD_IDLE) begin
               rej = 1'b1;
            end else begin
               cmd_in = action;
               idx_in = 5'd0;
               if (action == i2cmbc_pkg::ACT_WRITE) shift_in = tx_byte;
               if (action == i2cmbc_pkg::ACT_READ) begin
                  shift_in  = 8'd0;
                  ackout_in = ack_to_send;
               end
               pins_in  = set_phase(action, 5'd0, shift_in, ackout_in, pins_ff);
               timer_in = load_val;
            end
         end else if (action == i2cmbc_pkg::ACT_TICK && cmd_ff != i2cmbc_pkg::CMD_IDLE) begin
            timer_in = timer_dec;
            if (timer_dec == '0) begin
               // Samples taken at the end of the phase.
               if (cmd_ff == i2cmbc_pkg::ACT_WRITE && idx_ff == 5'd25) begin
                  ackflag_in = ~sda_in;
               end else if (cmd_ff == i2cmbc_pkg::ACT_READ && idx_ff >= 5'd2
                            && idx_ff <= 5'd16 && !idx_ff[0] && sda_in) begin
                  shift_in[rd_bit[2:0]] = 1'b1;
               end
               if (idx_inc >= i2cmbc_pkg::phase_count(cmd_ff)) begin
                  if (cmd_ff == i2cmbc_pkg::ACT_READ) rx_in = shift_in;
                  cmd_in = i2cmbc_pkg::CMD_IDLE;
                  idx_in = 5'd0;
                  done   = 1'b1;
               end else begin
                  idx_in   = idx_inc;
                  pins_in  = set_phase(cmd_ff, idx_inc, shift_in, ackout_ff, pins_ff);
                  timer_in = load_val;
               end
            end
         end
      end
   end

   // State registers and the phase length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= i2cmbc_pkg::PHASE_TICKS_RESET;
         cmd_ff         <= i2cmbc_pkg::CMD_IDLE;
         idx_ff         <= 5'd0;
         timer_ff       <= '0;
         shift_ff       <= 8'd0;
         ackflag_ff     <= 1'b0;
         ackout_ff      <= 1'b0;
         rx_ff          <= 8'd0;
         pins_ff        <= '{scl: 1'b1, sda: 1'b1, drive: 1'b1};
      end else begin
         if (csr_we) phase_ticks_ff <= csr_wdata;
         cmd_ff     <= cmd_in;
         idx_ff     <= idx_in;
         timer_ff   <= timer_in;
         shift_ff   <= shift_in;
         ackflag_ff <= ackflag_in;
         ackout_ff  <= ackout_in;
         rx_ff      <= rx_in;
         pins_ff    <= pins_in;
      end
   end

   // Result of this transfer, taken from the updated state.
   always_comb begin
      result.scl_level    = pins_in.scl;
      result.sda_level    = pins_in.sda;
      result.sda_drive    = pins_in.drive;
      result.busy_res     = (cmd_in != i2cmbc_pkg::CMD_IDLE);
      result.done_res     = done;
      result.ack_received = ackflag_in;
      result.rx_byte      = rx_in;
      result.rejected     = rej;
   end

endmodule

// ===== sv/i2cmbc_out_stage.sv =====
// ----------------------------------------------------------------------------
// I2C master byte controller output stage
// Result register that decouples the response channel from the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cmbc_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  i2cmbc_pkg::result_type in_data,
   output logic                   in_ready,
   i2cmbc_rsp_if.source           rsp_ch
);

   logic                   valid_ff;
   i2cmbc_pkg::result_type data_ff;

   // A new result may enter when the register is empty or being emptied.
   assign in_ready = !valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= in_data;
      end
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.scl_level    = data_ff.scl_level;
   assign rsp_ch.sda_level    = data_ff.sda_level;
   assign rsp_ch.sda_drive    = data_ff.sda_drive;
   assign rsp_ch.busy_res     = data_ff.busy_res;
   assign rsp_ch.done_res     = data_ff.done_res;
   assign rsp_ch.ack_received = data_ff.ack_received;
   assign rsp_ch.rx_byte      = data_ff.rx_byte;
   assign rsp_ch.rejected     = data_ff.rejected;

endmodule

// ===== sv/i2c_master_byte_controller.sv =====
// ----------------------------------------------------------------------------
// I2C master byte controller
// Output: the result of a transfer is registered and appears in the cycle after it is accepted.
// Throughput: one tick or command per cycle; the result register is the
// only stage, so a request is taken whenever it is empty or being read.
// Reset: synchronous, active high; bus idle with SCL and SDA high and driven,
// phase length 128 ticks, no result pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_master_byte_controller #(
   parameter int TIMER_WIDTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   i2cmbc_req_if.sink   req_ch,
   i2cmbc_rsp_if.source rsp_ch,
   input  logic         csr_we,
   input  logic [15:0]  csr_wdata
);

   logic                   stage_ready;
   logic                   accept;
   i2cmbc_pkg::result_type result;

   // A request transfer completes when the result register can take it.
   assign req_ch.ready = stage_ready;
   assign accept       = req_ch.valid && stage_ready;

   i2cmbc_sequencer #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .action      (req_ch.action),
      .tx_byte     (req_ch.tx_byte),
      .ack_to_send (req_ch.ack_to_send),
      .sda_in      (req_ch.sda_in),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .result      (result)
   );

   i2cmbc_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_data  (result),
      .in_ready (stage_ready),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ===== bench/i2c_master_byte_controller_tb.sv =====
// ----------------------------------------------------------------------------
// I2C master byte controller testbench
// Drives ticks and bus commands through the request channel. It predicts
// every result with its own model of the phase sequencer and checks each
// field of every result. The phase length is changed between phases of the
// run and covers zero, small lengths, the reset value and the full 16 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_master_byte_controller_tb;

   // Spare action codes that the block ignores.
   localparam logic [2:0] ACT_SPARE6 = 3'd6;
   localparam logic [2:0] ACT_SPARE7 = 3'd7;

   localparam int STALL_LIMIT = 1000;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] tx_byte;
      logic       ack_to_send;
      logic       sda_in;
   } bus_op_type;

   typedef enum logic [1:0] {SDA_RANDOM, SDA_LOW, SDA_HIGH} sda_mode_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic [15:0] csr_wdata;

   i2cmbc_req_if req_ch ();
   i2cmbc_rsp_if rsp_ch ();

   i2c_master_byte_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Stimulus and expectation stores.
   bus_op_type              queued_bus_ops[$];
   i2cmbc_pkg::result_type  predicted_results[$];
   int unsigned ops_unaccepted = 0;

   int snd_idle_pct;
   int rcv_idle_pct;
   int fail_count = 0;
   int results_checked = 0;
   int quiet_cycles = 0;
   int cmds_started = 0;
   int cmds_refused = 0;
   int cmds_done = 0;

   // Predicted sequencer state.
   logic [15:0] phase_len;
   logic [2:0]  cur_cmd;
   logic [4:0]  step_no;
   logic [15:0] tick_left;
   logic [7:0]  shreg;
   logic [7:0]  last_rx;
   logic        ack_seen;
   logic        ack_bit;
   logic        pin_scl;
   logic        pin_sda;
   logic        pin_oe;

   // Clock generation.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Number of bus phases in each command.
   function automatic int cmd_steps(logic [2:0] cmd);
      case (cmd)
         i2cmbc_pkg::ACT_START:   return 3;
         i2cmbc_pkg::ACT_RESTART: return 5;
         i2cmbc_pkg::ACT_STOP:    return 4;
         i2cmbc_pkg::ACT_WRITE:   return 27;
         i2cmbc_pkg::ACT_READ:    return 21;
         default:                 return 0;
      endcase
   endfunction

   // A phase length of zero still lasts one tick.
   function automatic logic [15:0] reload_ticks();
      return (phase_len == 16'd0) ? 16'd1 : phase_len;
   endfunction

   // Sets the bus pins for the phase that is starting.
   function automatic void drive_step_levels();
      int b;
      case (cur_cmd)
         i2cmbc_pkg::ACT_START: begin
            pin_oe = 1'b1;
            if (step_no == 0) pin_scl = 1'b1;
            else if (step_no == 1) pin_sda = 1'b0;
            else pin_scl = 1'b0;
         end
         i2cmbc_pkg::ACT_RESTART: begin
            pin_oe = 1'b1;
            if (step_no == 0) pin_scl = 1'b0;
            else if (step_no == 1) pin_sda = 1'b1;
            else if (step_no == 2) pin_scl = 1'b1;
            else if (step_no == 3) pin_sda = 1'b0;
            else pin_scl = 1'b0;
         end
         i2cmbc_pkg::ACT_STOP: begin
            pin_oe = 1'b1;
            if (step_no == 0) pin_sda = 1'b0;
            else if (step_no == 1) pin_scl = 1'b1;
            else if (step_no == 2) pin_sda = 1'b1;
         end
         i2cmbc_pkg::ACT_WRITE: begin
            // Three phases per data bit: clock low, data out, clock high.
            if (step_no < 24) begin
               b = step_no / 3;
               case (step_no % 3)
                  0: pin_scl = 1'b0;
                  1: begin
                     pin_sda = shreg[7 - b];
                     pin_oe = 1'b1;
                  end
                  default: pin_scl = 1'b1;
               endcase
            end else if (step_no == 25) begin
               pin_oe = 1'b0;
               pin_scl = 1'b1;
            end else begin
               pin_scl = 1'b0;
            end
         end
         i2cmbc_pkg::ACT_READ: begin
            if (step_no == 0) begin
               pin_scl = 1'b0;
            end else if (step_no <= 16) begin
               if (step_no == 1) begin
                  pin_oe = 1'b0;
                  pin_sda = 1'b1;
               end
               pin_scl = ~step_no[0];
            end else if (step_no == 17) begin
               pin_scl = 1'b0;
            end else if (step_no == 18) begin
               pin_oe = 1'b1;
               pin_sda = ~ack_bit;
            end else if (step_no == 19) begin
               pin_scl = 1'b1;
            end else begin
               pin_scl = 1'b0;
            end
         end
         default: ;
      endcase
   endfunction

   // Advances the predicted sequencer by one transfer and returns its result.
   function automatic i2cmbc_pkg::result_type predict_bus_item(logic [2:0] act,
                                                               logic [7:0] txb,
                                                               logic acks, logic sda);
      i2cmbc_pkg::result_type r;
      logic finished;
      logic refused;
      int b;
      finished = 1'b0;
      refused = 1'b0;
      if (act >= i2cmbc_pkg::ACT_START && act <= i2cmbc_pkg::ACT_READ) begin
         if (cur_cmd != i2cmbc_pkg::CMD_IDLE) begin
            refused = 1'b1;
            cmds_refused++;
         end else begin
            cur_cmd = act;
            step_no = 5'd0;
            if (act == i2cmbc_pkg::ACT_WRITE) shreg = txb;
            if (act == i2cmbc_pkg::ACT_READ) begin
               shreg = 8'd0;
               ack_bit = acks;
            end
            drive_step_levels();
            tick_left = reload_ticks();
            cmds_started++;
         end
      end else if (act == i2cmbc_pkg::ACT_TICK && cur_cmd != i2cmbc_pkg::CMD_IDLE) begin
         if (tick_left != 16'd0) tick_left = tick_left - 16'd1;
         if (tick_left == 16'd0) begin
            // Samples belong to the phase that this tick closes.
            if (cur_cmd == i2cmbc_pkg::ACT_WRITE && step_no == 25) begin
               ack_seen = ~sda;
            end else if (cur_cmd == i2cmbc_pkg::ACT_READ && step_no >= 2 && step_no <= 16 &&
                         !step_no[0]) begin
               b = (step_no - 2) / 2;
               if (sda) shreg[7 - b] = 1'b1;
            end
            step_no = step_no + 5'd1;
            if (step_no >= cmd_steps(cur_cmd)) begin
               if (cur_cmd == i2cmbc_pkg::ACT_READ) last_rx = shreg;
               cur_cmd = i2cmbc_pkg::CMD_IDLE;
               step_no = 5'd0;
               finished = 1'b1;
               cmds_done++;
            end else begin
               drive_step_levels();
               tick_left = reload_ticks();
            end
         end
      end
      r.scl_level = pin_scl;
      r.sda_level = pin_sda;
      r.sda_drive = pin_oe;
      r.busy_res = (cur_cmd != i2cmbc_pkg::CMD_IDLE);
      r.done_res = finished;
      r.ack_received = ack_seen;
      r.rx_byte = last_rx;
      r.rejected = refused;
      return r;
   endfunction

   function automatic string describe_result(i2cmbc_pkg::result_type r);
      return $sformatf("scl=%0b sda=%0b oe=%0b busy=%0b done=%0b ack=%0b rx=%02h rej=%0b",
                       r.scl_level, r.sda_level, r.sda_drive, r.busy_res, r.done_res,
                       r.ack_received, r.rx_byte, r.rejected);
   endfunction

   task automatic note_failure(string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("%s", msg);
   endtask

   task automatic queue_op(logic [2:0] act, logic [7:0] txb, logic acks, logic sda);
      bus_op_type op;
      op.action = act;
      op.tx_byte = txb;
      op.ack_to_send = acks;
      op.sda_in = sda;
      queued_bus_ops.push_back(op);
      ops_unaccepted++;
   endtask

   task automatic queue_ticks(int n, sda_mode_type mode);
      logic sda;
      for (int i = 0; i < n; i++) begin
         case (mode)
            SDA_LOW:  sda = 1'b0;
            SDA_HIGH: sda = 1'b1;
            default:  sda = 1'($urandom_range(0, 1));
         endcase
         queue_op(i2cmbc_pkg::ACT_TICK, 8'($urandom), 1'($urandom), sda);
      end
   endtask

   // Mostly complete commands with random content, some cut short or
   // overrun, with refused commands and ignored codes mixed in.
   task automatic queue_bus_traffic(int n, int eff_len);
      int made;
      int n_ticks;
      logic [2:0] cmd;
      made = 0;
      while (made < n) begin
         if ($urandom_range(0, 99) < 10) begin
            case ($urandom_range(0, 2))
               0: queue_op(ACT_SPARE6, 8'($urandom), 1'($urandom), 1'($urandom));
               1: queue_op(ACT_SPARE7, 8'($urandom), 1'($urandom), 1'($urandom));
               default: queue_op(i2cmbc_pkg::ACT_TICK, 8'($urandom), 1'($urandom),
                                 1'($urandom));
            endcase
            made++;
         end else begin
            case ($urandom_range(0, 7))
               0: cmd = i2cmbc_pkg::ACT_START;
               1: cmd = i2cmbc_pkg::ACT_RESTART;
               2: cmd = i2cmbc_pkg::ACT_STOP;
               3, 4, 5: cmd = i2cmbc_pkg::ACT_WRITE;
               default: cmd = i2cmbc_pkg::ACT_READ;
            endcase
            queue_op(cmd, 8'($urandom), 1'($urandom), 1'($urandom));
            n_ticks = cmd_steps(cmd) * eff_len;
            if ($urandom_range(0, 9) == 0) n_ticks = $urandom_range(0, n_ticks + 3 * eff_len);
            for (int i = 0; i < n_ticks; i++) begin
               if ($urandom_range(0, 19) == 0) begin
                  queue_op(3'($urandom_range(i2cmbc_pkg::ACT_START, i2cmbc_pkg::ACT_READ)),
                           8'($urandom), 1'($urandom), 1'($urandom));
                  made++;
               end
               queue_op(i2cmbc_pkg::ACT_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
            end
            made += n_ticks + 1;
         end
      end
   endtask

   task automatic wait_until_drained();
      while (ops_unaccepted != 0 || predicted_results.size() != 0) @(posedge clock);
   endtask

   // The register is only written with nothing in flight.
   task automatic set_phase_ticks(logic [15:0] value);
      wait_until_drained();
      repeat (3) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      phase_len = value;
   endtask

   // Request driver: presents queued operations and predicts each transfer.
   always @(posedge clock) begin : req_driver
      bus_op_type op;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predicted_results.push_back(predict_bus_item(req_ch.action, req_ch.tx_byte,
                                                         req_ch.ack_to_send, req_ch.sda_in));
            ops_unaccepted--;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (queued_bus_ops.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
               op = queued_bus_ops.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.action <= op.action;
               req_ch.tx_byte <= op.tx_byte;
               req_ch.ack_to_send <= op.ack_to_send;
               req_ch.sda_in <= op.sda_in;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: stalls at random and checks each transfer in order.
   always @(posedge clock) begin : rsp_monitor
      i2cmbc_pkg::result_type seen;
      i2cmbc_pkg::result_type want;
      string bad;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.scl_level = rsp_ch.scl_level;
            seen.sda_level = rsp_ch.sda_level;
            seen.sda_drive = rsp_ch.sda_drive;
            seen.busy_res = rsp_ch.busy_res;
            seen.done_res = rsp_ch.done_res;
            seen.ack_received = rsp_ch.ack_received;
            seen.rx_byte = rsp_ch.rx_byte;
            seen.rejected = rsp_ch.rejected;
            results_checked++;
            if (predicted_results.size() == 0) begin
               note_failure($sformatf("Unexpected result %s", describe_result(seen)));
            end else begin
               want = predicted_results.pop_front();
               bad = "";
               if (seen.scl_level !== want.scl_level) bad = {bad, " scl_level"};
               if (seen.sda_level !== want.sda_level) bad = {bad, " sda_level"};
               if (seen.sda_drive !== want.sda_drive) bad = {bad, " sda_drive"};
               if (seen.busy_res !== want.busy_res) bad = {bad, " busy_res"};
               if (seen.done_res !== want.done_res) bad = {bad, " done_res"};
               if (seen.ack_received !== want.ack_received) bad = {bad, " ack_received"};
               if (seen.rx_byte !== want.rx_byte) bad = {bad, " rx_byte"};
               if (seen.rejected !== want.rejected) bad = {bad, " rejected"};
               if (bad != "")
                  note_failure($sformatf("Result %0d wrong in%s: expected %s, got %s",
                                         results_checked, bad, describe_result(want),
                                         describe_result(seen)));
            end
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
   end

   // Ends the run when no transfer happens on either channel for too long.
   always @(posedge clock) begin : stall_watchdog
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timed out after %0d cycles without a transfer", quiet_cycles);
         $display("status: fail");
         $finish;
      end
   end

   initial begin : stimulus
      // Known levels on every input from time zero.
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = 16'd0;
      req_ch.valid = 1'b0;
      req_ch.action = i2cmbc_pkg::ACT_TICK;
      req_ch.tx_byte = 8'd0;
      req_ch.ack_to_send = 1'b0;
      req_ch.sda_in = 1'b0;
      rsp_ch.ready = 1'b0;
      phase_len = i2cmbc_pkg::PHASE_TICKS_RESET;
      cur_cmd = i2cmbc_pkg::CMD_IDLE;
      step_no = 5'd0;
      tick_left = 16'd0;
      shreg = 8'd0;
      last_rx = 8'd0;
      ack_seen = 1'b0;
      ack_bit = 1'b0;
      pin_scl = 1'b1;
      pin_sda = 1'b1;
      pin_oe = 1'b1;
      snd_idle_pct = 7;
      rcv_idle_pct = 63;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset phase length: idle ticks, ignored codes and one full start
      // condition with every other command refused while it runs.
      queue_op(i2cmbc_pkg::ACT_TICK, 8'h00, 1'b0, 1'b0);
      queue_op(i2cmbc_pkg::ACT_TICK, 8'hFF, 1'b1, 1'b1);
      queue_op(ACT_SPARE6, 8'hFF, 1'b1, 1'b1);
      queue_op(ACT_SPARE7, 8'h00, 1'b0, 1'b0);
      queue_op(i2cmbc_pkg::ACT_START, 8'h00, 1'b0, 1'b0);
      queue_op(i2cmbc_pkg::ACT_RESTART, 8'h00, 1'b0, 1'b0);
      queue_op(i2cmbc_pkg::ACT_STOP, 8'h00, 1'b0, 1'b0);
      queue_op(i2cmbc_pkg::ACT_WRITE, 8'hFF, 1'b1, 1'b1);
      queue_op(i2cmbc_pkg::ACT_READ, 8'hFF, 1'b1, 1'b1);
      queue_op(i2cmbc_pkg::ACT_START, 8'h00, 1'b0, 1'b0);
      queue_ticks(127, SDA_RANDOM);
      queue_op(i2cmbc_pkg::ACT_WRITE, 8'h5A, 1'b0, 1'b0);
      queue_ticks(3 * 128 - 127 + 1, SDA_RANDOM);

      // Zero length runs as one tick per phase; each command in turn, with acked
      // and unacked writes, a refused read and reads of all ones and all zeros.
      set_phase_ticks(16'd0);
      queue_op(i2cmbc_pkg::ACT_START, 8'h00, 1'b1, 1'b0);
      queue_ticks(3, SDA_RANDOM);
      queue_op(i2cmbc_pkg::ACT_WRITE, 8'hFF, 1'b0, 1'b1);
      queue_ticks(27, SDA_LOW);
      queue_op(i2cmbc_pkg::ACT_READ, 8'h00, 1'b1, 1'b0);
      queue_ticks(21, SDA_HIGH);
      queue_op(i2cmbc_pkg::ACT_WRITE, 8'h00, 1'b1, 1'b0);
      queue_op(i2cmbc_pkg::ACT_READ, 8'hFF, 1'b1, 1'b1);
      queue_ticks(27, SDA_HIGH);
      queue_op(i2cmbc_pkg::ACT_READ, 8'hFF, 1'b0, 1'b1);
      queue_ticks(21, SDA_LOW);
      queue_op(i2cmbc_pkg::ACT_RESTART, 8'h00, 1'b0, 1'b0);
      queue_ticks(5, SDA_RANDOM);
      queue_op(i2cmbc_pkg::ACT_STOP, 8'h00, 1'b0, 1'b0);
      queue_ticks(4, SDA_RANDOM);

      set_phase_ticks(16'd2);
      queue_bus_traffic(500, 2);

      // Sender now the slower side.
      set_phase_ticks(16'd1);
      snd_idle_pct = 63;
      rcv_idle_pct = 7;
      queue_bus_traffic(500, 1);

      // Full rate on both sides, then enough ticks to finish any command.
      set_phase_ticks(16'd3);
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      queue_bus_traffic(300, 3);
      queue_ticks(27 * 3 + 10, SDA_RANDOM);

      // Longest phase: a start condition that stays in its first phase,
      // with a read refused while it waits.
      set_phase_ticks(16'hFFFF);
      queue_op(i2cmbc_pkg::ACT_START, 8'h00, 1'b0, 1'b0);
      queue_ticks(20, SDA_RANDOM);
      queue_op(i2cmbc_pkg::ACT_READ, 8'hA5, 1'b1, 1'b0);
      queue_ticks(20, SDA_RANDOM);

      wait_until_drained();
      repeat (5) @(posedge clock);
      $display("Checked %0d results with phase lengths of 128, 0, 2, 1, 3 and 65535 ticks.",
               results_checked);
      $display("Commands started %0d, completed %0d, refused while busy %0d.",
               cmds_started, cmds_done, cmds_refused);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches in total", fail_count);
         $display("status: fail");
      end
      $finish;
   end

endmodule
